// File: rtl/fixed_partition_allocator_macros.svh
// Assertion helpers used by the top-level allocator file.
`ifndef FIXED_PARTITION_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define FPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int NUM_PARTITIONS    = 5;
  localparam int LARGEST_PARTITION = 8;

  // Fixed field widths.
  localparam int ID_W      = 8;
  localparam int SIZE_W    = 4;
  localparam int INDEX_W   = 3;
  localparam int STATUS_W  = 2;
  localparam int POLICY_W  = 2;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 8;

  localparam int IDX_W   = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int PSIZE_W = $clog2(LARGEST_PARTITION + 1);
  localparam int CMP_W   = (PSIZE_W > SIZE_W) ? PSIZE_W : SIZE_W;

  // Operation codes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Fit policies.
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic accept;  // an input item is taken this cycle
    logic cfg_we;  // the policy register is written this cycle
  } ctrl_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic                granted;
  } result_t;

  // Partition i holds max(LARGEST_PARTITION >> i, 1) units.
  function automatic logic [CMP_W-1:0] part_size(input int idx);
    int s;
    s = LARGEST_PARTITION >> idx;
    if (s == 0) begin
      s = 1;
    end
    return CMP_W'(s);
  endfunction

endpackage

// File: rtl/fpa_ctrl.sv
module fpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  output fpa_pkg::ctrl_cmd_t cmd_o
);
  import fpa_pkg::*;

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // The output register frees up in the same cycle the receiver takes it.
  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_FULL);
  assign cfg_ready_o = 1'b1;

  assign cmd_o.accept = accept;
  assign cmd_o.cfg_we = cfg_valid_i;

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_FULL;
    end else if (out_ready_i) begin
      state_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/fpa_datapath.sv
module fpa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpa_pkg::ctrl_cmd_t            cmd_i,
  input  logic                          operation_i,
  input  logic [fpa_pkg::ID_W-1:0]      process_id_i,
  input  logic [fpa_pkg::SIZE_W-1:0]    size_needed_i,
  input  logic [fpa_pkg::POLICY_W-1:0]  cfg_policy_i,
  output fpa_pkg::result_t              result_o
);
  import fpa_pkg::*;

  logic [ID_W-1:0]     owner_q [NUM_PARTITIONS];
  logic [IDX_W-1:0]    next_start_q;
  logic [POLICY_W-1:0] policy_q;
  result_t             result_q;

  logic [NUM_PARTITIONS-1:0] fit;
  logic [NUM_PARTITIONS-1:0] own_hit;
  logic [CMP_W-1:0]          need;

  logic             first_found, hi_found, best_found, worst_found, rel_found;
  logic [IDX_W-1:0] first_sel, hi_sel, best_sel, worst_sel, rel_sel;
  logic [CMP_W-1:0] best_size, worst_size;

  logic             alloc_found;
  logic [IDX_W-1:0] alloc_sel;
  logic             do_alloc, do_release;
  result_t          result_d;

  assign need = CMP_W'(size_needed_i);

  always_comb begin
    for (int i = 0; i < NUM_PARTITIONS; i++) begin
      fit[i]     = (owner_q[i] == '0) && (part_size(i) >= need);
      own_hit[i] = (owner_q[i] == process_id_i);
    end
  end

  // Priority searches over the partitions; sizes are constants per index.
  always_comb begin
    first_found = 1'b0;
    first_sel   = '0;
    hi_found    = 1'b0;
    hi_sel      = '0;
    rel_found   = 1'b0;
    rel_sel     = '0;
    for (int i = NUM_PARTITIONS - 1; i >= 0; i--) begin
      if (fit[i]) begin
        first_found = 1'b1;
        first_sel   = IDX_W'(i);
      end
      if (fit[i] && (IDX_W'(i) >= next_start_q)) begin
        hi_found = 1'b1;
        hi_sel   = IDX_W'(i);
      end
      if (own_hit[i]) begin
        rel_found = 1'b1;
        rel_sel   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    best_found  = 1'b0;
    best_sel    = '0;
    best_size   = '0;
    worst_found = 1'b0;
    worst_sel   = '0;
    worst_size  = '0;
    for (int i = 0; i < NUM_PARTITIONS; i++) begin
      if (fit[i] && (!best_found || (part_size(i) < best_size))) begin
        best_found = 1'b1;
        best_sel   = IDX_W'(i);
        best_size  = part_size(i);
      end
      if (fit[i] && (!worst_found || (part_size(i) > worst_size))) begin
        worst_found = 1'b1;
        worst_sel   = IDX_W'(i);
        worst_size  = part_size(i);
      end
    end
  end

  always_comb begin
    unique case (policy_q)
      POL_FIRST: begin
        alloc_found = first_found;
        alloc_sel   = first_sel;
      end
      POL_NEXT: begin
        // Search from next_start to the top, then wrap to the bottom.
        alloc_found = first_found;
        alloc_sel   = hi_found ? hi_sel : first_sel;
      end
      POL_BEST: begin
        alloc_found = best_found;
        alloc_sel   = best_sel;
      end
      POL_WORST: begin
        alloc_found = worst_found;
        alloc_sel   = worst_sel;
      end
      default: begin
        alloc_found = 1'b0;
        alloc_sel   = '0;
      end
    endcase
  end

  always_comb begin
    do_alloc   = 1'b0;
    do_release = 1'b0;
    result_d   = '{status: STAT_NO_FIT, index: '0, granted: 1'b0};
    if (operation_i == OP_ALLOC) begin
      if ((process_id_i != '0) && alloc_found) begin
        do_alloc = 1'b1;
        result_d = '{status: STAT_OK, index: INDEX_W'(alloc_sel), granted: 1'b1};
      end
    end else begin
      result_d.status = STAT_NOT_FOUND;
      if ((process_id_i != '0) && rel_found) begin
        do_release = 1'b1;
        result_d = '{status: STAT_OK, index: INDEX_W'(rel_sel), granted: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PARTITIONS; i++) begin
        owner_q[i] <= '0;
      end
      next_start_q <= '0;
      policy_q     <= POL_FIRST;
    end else begin
      if (cmd_i.cfg_we) begin
        policy_q <= cfg_policy_i;
      end
      if (cmd_i.accept && do_alloc) begin
        owner_q[alloc_sel] <= process_id_i;
        if (policy_q == POL_NEXT) begin
          next_start_q <= (alloc_sel == IDX_W'(NUM_PARTITIONS - 1)) ? '0 : alloc_sel + 1'b1;
        end
      end
      if (cmd_i.accept && do_release) begin
        owner_q[rel_sel] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// File: rtl/fixed_partition_allocator.sv
// Fixed partition allocator: five partitions of 8, 4, 2, 1 and 1 units.
// Input channel s_axis_*: tuser carries the operation (allocate or release),
// tdata the process id and the requested size. Every item gives exactly one
// result item on m_axis_*: grant flag, partition index and status.
// The fit policy (first, next, best or worst fit) is written through the
// cfg_* channel, which is always ready; write it only while the block is idle.
// An accepted item shows its result at the output from the next cycle on. The
// owner table is searched by parallel comparators in the cycle of acceptance, so
// one item per cycle is taken while the output is not stalled.
// The single output register holds a result until the receiver takes it; a new
// item is accepted in the same cycle that the held result is taken, so a stall
// at the output stops the input after one item.
// Reset frees all partitions, selects first fit and clears the next-fit start.
module fixed_partition_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fpa_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // process_id, size_needed
  input  logic                             s_axis_tuser,  // operation
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [fpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // granted, partition_index, status
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fpa_pkg::POLICY_W-1:0]     cfg_data_i     // fit_policy
);
  import fpa_pkg::*;

  `include "fixed_partition_allocator_macros.svh"

  ctrl_cmd_t cmd;
  result_t   result;

  fpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  fpa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (s_axis_tuser),
    .process_id_i  (s_axis_tdata[ID_W-1:0]),
    .size_needed_i (s_axis_tdata[ID_W +: SIZE_W]),
    .cfg_policy_i  (cfg_data_i),
    .result_o      (result)
  );

  assign m_axis_tdata = OUT_DATA_W'(result);

  // A granted result always reports success, a refused one reports index zero.
  `FPA_ASSERT_NOW(a_grant_ok, m_axis_tvalid && result.granted, result.status == STAT_OK)
  `FPA_ASSERT_NOW(a_refuse_idx, m_axis_tvalid && !result.granted, result.index == '0)
  // A held result blocks the input until it is taken.
  `FPA_ASSERT_NOW(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  // An accepted item shows its result in the next cycle.
  `FPA_ASSERT_NEXT(a_result_next, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpa_pkg::*;

  localparam int RUN_LIMIT_NS = 400_000;
  localparam int ITEMS_PER_SEG = 56;
  localparam int NUM_SEGS = 8;

  typedef struct packed {
    logic                is_cfg;
    logic [POLICY_W-1:0] pol;
    logic                op;
    logic [ID_W-1:0]     id;
    logic [SIZE_W-1:0]   size;
    logic                typed;
    logic                granted;
    logic [INDEX_W-1:0]  index;
    logic [STATUS_W-1:0] status;
  } dir_row_t;

  // The opening rows are read off directly; later rows rely on the predictor.
  localparam dir_row_t DIR_ROWS [0:29] = '{
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd5,   4'd1,  1'b1, 1'b0, 3'd0, STAT_NOT_FOUND},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd0,   4'd1,  1'b1, 1'b0, 3'd0, STAT_NO_FIT},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd0,   4'd1,  1'b1, 1'b0, 3'd0, STAT_NOT_FOUND},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd1,   4'd9,  1'b1, 1'b0, 3'd0, STAT_NO_FIT},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd2,   4'd15, 1'b1, 1'b0, 3'd0, STAT_NO_FIT},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd255, 4'd8,  1'b1, 1'b1, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd128, 4'd0,  1'b1, 1'b1, 3'd1, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd128, 4'd2,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd3,   4'd1,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd4,   4'd1,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd6,   4'd1,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd128, 4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd128, 4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd128, 4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b1, POL_NEXT,  OP_ALLOC,   8'd0,   4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd7,   4'd1,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd8,   4'd1,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd255, 4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd9,   4'd1,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b1, POL_BEST,  OP_ALLOC,   8'd0,   4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd7,   4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd3,   4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd4,   4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd10,  4'd1,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd11,  4'd4,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b1, POL_WORST, OP_ALLOC,   8'd0,   4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd10,  4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_RELEASE, 8'd11,  4'd0,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd12,  4'd1,  1'b0, 1'b0, 3'd0, STAT_OK},
    '{1'b0, POL_FIRST, OP_ALLOC,   8'd13,  4'd1,  1'b0, 1'b0, 3'd0, STAT_OK}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [POLICY_W-1:0]   cfg_data_i;

  // Predictor state: the owner table, the next-fit start and the policy.
  logic [ID_W-1:0]     owner_tab [NUM_PARTITIONS];
  logic [INDEX_W-1:0]  next_fit_ptr;
  logic [POLICY_W-1:0] fit_policy_q;

  result_t pending_results [$];
  int      err_cnt = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;

  fixed_partition_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int units_of(int idx);
    int s;
    s = LARGEST_PARTITION >> idx;
    return (s == 0) ? 1 : s;
  endfunction

  function automatic result_t allocate_or_release(logic op, logic [ID_W-1:0] id,
                                                  logic [SIZE_W-1:0] need);
    result_t res;
    int pick;
    int k;
    res = '{status: STAT_OK, index: '0, granted: 1'b0};
    pick = NUM_PARTITIONS;
    if (next_fit_ptr >= NUM_PARTITIONS) begin
      next_fit_ptr = '0;
    end
    if (op == OP_ALLOC) begin
      res.status = STAT_NO_FIT;
      if (id != 0) begin
        for (int j = 0; j < NUM_PARTITIONS; j++) begin
          k = (fit_policy_q == POL_NEXT) ? (int'(next_fit_ptr) + j) % NUM_PARTITIONS : j;
          if (owner_tab[k] == 0 && units_of(k) >= int'(need)) begin
            case (fit_policy_q)
              POL_FIRST, POL_NEXT: begin
                if (pick == NUM_PARTITIONS) pick = k;
              end
              POL_BEST: begin
                if (pick == NUM_PARTITIONS || units_of(k) < units_of(pick)) pick = k;
              end
              default: begin
                if (pick == NUM_PARTITIONS || units_of(k) > units_of(pick)) pick = k;
              end
            endcase
          end
        end
        if (pick < NUM_PARTITIONS) begin
          owner_tab[pick] = id;
          if (fit_policy_q == POL_NEXT) begin
            next_fit_ptr = INDEX_W'((pick + 1) % NUM_PARTITIONS);
          end
          res = '{status: STAT_OK, index: INDEX_W'(pick), granted: 1'b1};
        end
      end
    end else begin
      res.status = STAT_NOT_FOUND;
      if (id != 0) begin
        // Only the lowest partition held by this id is freed.
        for (int j = 0; j < NUM_PARTITIONS; j++) begin
          if (pick == NUM_PARTITIONS && owner_tab[j] == id) pick = j;
        end
        if (pick < NUM_PARTITIONS) begin
          owner_tab[pick] = '0;
          res = '{status: STAT_OK, index: INDEX_W'(pick), granted: 1'b1};
        end
      end
    end
    return res;
  endfunction

  task automatic send_request(logic op, logic [ID_W-1:0] id, logic [SIZE_W-1:0] need,
                              logic use_typed, result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, need, id};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = allocate_or_release(op, id, need);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_policy(logic [POLICY_W-1:0] pol);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pol;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    fit_policy_q = pol;
  endtask

  // Mostly allocations and releases of ids that hold a partition, plus some
  // refused or malformed requests.
  task automatic send_random_request();
    logic            op;
    logic [ID_W-1:0] id;
    logic [SIZE_W-1:0] need;
    int r;
    r = $urandom_range(99);
    need = SIZE_W'($urandom_range(1, LARGEST_PARTITION));
    if (r < 55) begin
      op = OP_ALLOC;
      id = ($urandom_range(3) == 0) ? ID_W'($urandom_range(1, 255))
                                    : ID_W'($urandom_range(1, 6));
    end else if (r < 85) begin
      op = OP_RELEASE;
      id = owner_tab[$urandom_range(NUM_PARTITIONS - 1)];
      if (id == 0) id = ID_W'($urandom_range(1, 6));
    end else begin
      case ($urandom_range(3))
        0: begin
          op = OP_ALLOC;
          id = '0;
          need = SIZE_W'($urandom_range(0, 15));
        end
        1: begin
          op = OP_ALLOC;
          id = ID_W'($urandom_range(1, 255));
          need = ($urandom_range(1) == 0) ? '0 : SIZE_W'($urandom_range(9, 15));
        end
        2: begin
          op = OP_RELEASE;
          id = '0;
          need = SIZE_W'($urandom_range(0, 15));
        end
        default: begin
          op = OP_RELEASE;
          id = ID_W'($urandom_range(1, 255));
        end
      endcase
    end
    send_request(op, id, need, 1'b0, '0);
  endtask

  function automatic void check_result(logic [OUT_DATA_W-1:0] d);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result item with none expected, actual %h", $time, d);
      err_cnt++;
      return;
    end
    want = pending_results.pop_front();
    if (d[0] !== want.granted) begin
      $display("%0t: granted expected %0d actual %0d", $time, want.granted, d[0]);
      err_cnt++;
    end
    if (d[3:1] !== want.index) begin
      $display("%0t: partition_index expected %0d actual %0d", $time, want.index, d[3:1]);
      err_cnt++;
    end
    if (d[5:4] !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, d[5:4]);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
    end
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ALLOC;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = POL_FIRST;
    foreach (owner_tab[j]) owner_tab[j] = '0;
    next_fit_ptr = '0;
    fit_policy_q = POL_FIRST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[n]) begin
      if (DIR_ROWS[n].is_cfg) begin
        wait_drained();
        write_policy(DIR_ROWS[n].pol);
      end else begin
        send_request(DIR_ROWS[n].op, DIR_ROWS[n].id, DIR_ROWS[n].size, DIR_ROWS[n].typed,
                     '{status: DIR_ROWS[n].status, index: DIR_ROWS[n].index,
                       granted: DIR_ROWS[n].granted});
      end
    end

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_drained();
      write_policy((seg < 4) ? POLICY_W'(seg) : POLICY_W'($urandom_range(3)));
      case (seg / 2)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      repeat (ITEMS_PER_SEG) send_random_request();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
